[rtl/nvs_pkg.sv]
`timescale 1ns / 1ps

package nvs_pkg;

  localparam int TABLE_ENTRIES_DEF = 64;
  localparam int NAME_BYTES_DEF    = 16;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_SET    = 1'b1;

  localparam logic [1:0] STATUS_LOOKUP   = 2'd0;
  localparam logic [1:0] STATUS_UPDATED  = 2'd1;
  localparam logic [1:0] STATUS_INSERTED = 2'd2;
  localparam logic [1:0] STATUS_FULL     = 2'd3;

  typedef struct packed {
    logic               opcode;
    logic [63:0]        key_chars_low;
    logic [55:0]        key_chars_high;
    logic [7:0]         key_length;
    logic signed [31:0] new_value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic               found;
    logic [1:0]         status;
    logic [5:0]         entry_index;
    logic [6:0]         entries_used;
  } rsp_t;

  typedef enum logic [1:0] {
    CTL_IDLE,
    CTL_SCAN,
    CTL_COMMIT
  } ctl_state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic match;
    logic exhausted;
    logic out_free;
  } dp_sts_t;

endpackage

[rtl/nvs_ctrl.sv]
`timescale 1ns / 1ps

module nvs_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_stall,
  output nvs_pkg::dp_cmd_t dp_cmd,
  input  nvs_pkg::dp_sts_t dp_sts
);
  import nvs_pkg::*;

  ctl_state_t state;
  ctl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CTL_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    dp_cmd     = '0;
    cmd_stall  = 1'b1;
    case (state)
      CTL_IDLE: begin
        cmd_stall = 1'b0;
        if (cmd_valid) begin
          dp_cmd.load = 1'b1;
          state_next  = CTL_SCAN;
        end
      end
      CTL_SCAN: begin
        dp_cmd.scan = 1'b1;
        // Stop at the first (lowest) matching entry, or once every entry was compared.
        if (dp_sts.match || dp_sts.exhausted) begin
          state_next = CTL_COMMIT;
        end
      end
      CTL_COMMIT: begin
        if (dp_sts.out_free) begin
          dp_cmd.commit = 1'b1;
          state_next    = CTL_IDLE;
        end
      end
      default: begin
        state_next = CTL_IDLE;
      end
    endcase
  end

endmodule

[rtl/nvs_dp.sv]
`timescale 1ns / 1ps

module nvs_dp #(
  parameter int TABLE_ENTRIES = nvs_pkg::TABLE_ENTRIES_DEF,
  parameter int NAME_BYTES    = nvs_pkg::NAME_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  nvs_pkg::req_t    req,
  input  nvs_pkg::dp_cmd_t dp_cmd,
  output nvs_pkg::dp_sts_t dp_sts,
  output nvs_pkg::rsp_t    rsp,
  output logic             rsp_valid,
  input  logic             rsp_stall
);
  import nvs_pkg::*;

  localparam int MAX_CHARS = NAME_BYTES - 1;
  localparam int LEN_W     = $clog2(NAME_BYTES);
  localparam int IDX_W     = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W     = $clog2(TABLE_ENTRIES + 1);
  localparam int CHARS_W   = 64 + 56;
  localparam int NAME_W    = CHARS_W + LEN_W;

  // Name and value live in separate memories so an update writes only the value.
  logic [NAME_W-1:0] name_mem  [TABLE_ENTRIES];
  logic [31:0]       value_mem [TABLE_ENTRIES];

  logic [NAME_W-1:0] rd_name;
  logic [31:0]       rd_value;
  logic              rd_valid;
  logic [IDX_W-1:0]  rd_idx;

  logic              key_op;
  logic [63:0]       key_lo;
  logic [55:0]       key_hi;
  logic [7:0]        key_len;
  logic [LEN_W-1:0]  key_keep;
  logic [31:0]       key_value;

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [CNT_W-1:0]  addr;
  logic              hit;
  logic [IDX_W-1:0]  hit_idx;
  logic [31:0]       hit_value;

  logic [7:0]        keep_full;
  logic [63:0]       mask_lo;
  logic [55:0]       mask_hi;
  logic              issue;
  logic              match;
  logic              table_full;
  logic              ins;
  logic              upd;
  logic [IDX_W-1:0]  wr_addr;
  rsp_t              rsp_next;

  // Characters at or beyond the kept length are never stored or compared.
  always_comb begin
    keep_full = (req.key_length < 8'(MAX_CHARS)) ? req.key_length : 8'(MAX_CHARS);
    for (int b = 0; b < 8; b++) begin
      mask_lo[b*8 +: 8] = (8'(b) < keep_full) ? 8'hFF : 8'h00;
    end
    for (int b = 0; b < 7; b++) begin
      mask_hi[b*8 +: 8] = (8'(b + 8) < keep_full) ? 8'hFF : 8'h00;
    end
  end

  assign issue = dp_cmd.scan && (addr < count);
  assign match = rd_valid
                 && (rd_name[NAME_W-1:LEN_W] == {key_lo, key_hi})
                 && (8'(rd_name[LEN_W-1:0]) == key_len);

  assign dp_sts.match     = match;
  assign dp_sts.exhausted = (addr >= count) && !rd_valid;
  assign dp_sts.out_free  = !rsp_valid || !rsp_stall;

  assign table_full = (count >= CNT_W'(TABLE_ENTRIES));
  assign ins        = (key_op == OP_SET) && !hit && !table_full;
  assign upd        = (key_op == OP_SET) && hit;
  assign wr_addr    = hit ? hit_idx : count[IDX_W-1:0];
  assign count_next = ins ? count + CNT_W'(1) : count;

  always_comb begin
    rsp_next.found        = hit;
    rsp_next.entries_used = 7'(count_next);
    if (key_op == OP_SET) begin
      rsp_next.read_value = key_value;
      if (hit) begin
        rsp_next.status = STATUS_UPDATED;
      end else if (ins) begin
        rsp_next.status = STATUS_INSERTED;
      end else begin
        rsp_next.status = STATUS_FULL;
      end
    end else begin
      rsp_next.read_value = hit ? hit_value : 32'd0;
      rsp_next.status     = STATUS_LOOKUP;
    end
    if (hit) begin
      rsp_next.entry_index = 6'(hit_idx);
    end else if (ins) begin
      rsp_next.entry_index = 6'(count);
    end else begin
      rsp_next.entry_index = 6'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.commit && ins) begin
      name_mem[wr_addr] <= {key_lo, key_hi, key_keep};
    end
    if (dp_cmd.commit && (ins || upd)) begin
      value_mem[wr_addr] <= key_value;
    end
    if (issue) begin
      rd_name  <= name_mem[addr[IDX_W-1:0]];
      rd_value <= value_mem[addr[IDX_W-1:0]];
      rd_idx   <= addr[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      key_op    <= req.opcode;
      key_lo    <= req.key_chars_low & mask_lo;
      key_hi    <= req.key_chars_high & mask_hi;
      key_len   <= req.key_length;
      key_keep  <= keep_full[LEN_W-1:0];
      key_value <= req.new_value;
    end
    if (dp_cmd.scan && match) begin
      hit_idx   <= rd_idx;
      hit_value <= rd_value;
    end
    if (dp_cmd.commit) begin
      rsp <= rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      addr      <= '0;
      rd_valid  <= 1'b0;
      hit       <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (dp_cmd.load) begin
        addr     <= '0;
        rd_valid <= 1'b0;
        hit      <= 1'b0;
      end else if (dp_cmd.scan) begin
        rd_valid <= issue;
        if (issue) begin
          addr <= addr + CNT_W'(1);
        end
        if (match) begin
          hit <= 1'b1;
        end
      end
      if (dp_cmd.commit) begin
        count <= count_next;
      end
      if (dp_cmd.commit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

[rtl/named_variable_store.sv]
`timescale 1ns / 1ps

// Named variable store: up to TABLE_ENTRIES signed 32-bit variables, each keyed by a name
// of up to NAME_BYTES-1 characters. A lookup request returns the value of the lowest entry
// whose name equals the key exactly (or 0 with found clear); a set request updates that
// entry, or appends a new one with the name cut to NAME_BYTES-1 characters, and is dropped
// with status full when the table has no room. Keys longer than NAME_BYTES-1 characters
// never match. Names are held in a single-port table that is searched one entry per clock,
// from the lowest entry up until a match or the last entry in use has been compared; the
// next request is accepted once the result has been written to the output register, which
// holds it until it is taken, so a result that is not taken holds the next request back
// before that request's own result can be written.
module named_variable_store #(
  parameter int TABLE_ENTRIES = nvs_pkg::TABLE_ENTRIES_DEF,
  parameter int NAME_BYTES    = nvs_pkg::NAME_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  nvs_pkg::req_t cmd,
  output logic          result_valid,
  input  logic          result_stall,
  output nvs_pkg::rsp_t result
);
  import nvs_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  nvs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .dp_cmd    (dp_cmd),
    .dp_sts    (dp_sts)
  );

  nvs_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .NAME_BYTES    (NAME_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (cmd),
    .dp_cmd    (dp_cmd),
    .dp_sts    (dp_sts),
    .rsp       (result),
    .rsp_valid (result_valid),
    .rsp_stall (result_stall)
  );

endmodule

[test/tb_named_variable_store.sv]
`timescale 1ns / 1ps

module tb_named_variable_store;
  import nvs_pkg::*;

  localparam int TABLE_ENTRIES  = TABLE_ENTRIES_DEF;
  localparam int MAX_CHARS      = NAME_BYTES_DEF - 1;
  localparam int RANDOM_ITEMS   = 1728;
  localparam int POOL_NAMES     = 80;
  localparam int PRESSURE_AT    = 500;
  localparam int PRESSURE_HOLD  = 250;
  localparam int DRAIN_CYCLES   = 100;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    req_t req;
    logic typed;
    rsp_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  req_t cmd = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  rsp_t result;

  // Shadow copy of the table, updated in request order.
  logic [63:0]        name_low_tbl  [TABLE_ENTRIES];
  logic [55:0]        name_high_tbl [TABLE_ENTRIES];
  logic [7:0]         name_len_tbl  [TABLE_ENTRIES];
  logic signed [31:0] value_tbl     [TABLE_ENTRIES];
  int                 used_count = 0;

  rsp_t expected_results[$];
  row_t directed_rows[$];
  logic [119:0] pool_chars [POOL_NAMES];
  int           pool_len   [POOL_NAMES];
  int           failures = 0;
  int           idle_cycles = 0;

  named_variable_store DUT (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_stall    (cmd_stall),
    .cmd          (cmd),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic rsp_t store_access(input req_t r);
    rsp_t o;
    int keep;
    int idx;
    logic hit;
    logic [63:0] lo;
    logic [55:0] hi;
    keep = (r.key_length < MAX_CHARS) ? int'(r.key_length) : MAX_CHARS;
    lo = '0;
    hi = '0;
    for (int b = 0; b < 8; b++) if (b < keep) lo[8*b +: 8] = r.key_chars_low[8*b +: 8];
    for (int b = 0; b < 7; b++) if (b + 8 < keep) hi[8*b +: 8] = r.key_chars_high[8*b +: 8];
    hit = 1'b0;
    idx = 0;
    // A key longer than the name field can never equal a stored length.
    if (r.key_length <= MAX_CHARS) begin
      for (int i = 0; i < used_count; i++) begin
        if (!hit && name_len_tbl[i] == r.key_length && name_low_tbl[i] == lo &&
            name_high_tbl[i] == hi) begin
          hit = 1'b1;
          idx = i;
        end
      end
    end
    o.found = hit;
    if (r.opcode == OP_LOOKUP) begin
      o.read_value = hit ? value_tbl[idx] : 32'sd0;
      o.status = STATUS_LOOKUP;
    end else begin
      o.read_value = r.new_value;
      if (hit) begin
        value_tbl[idx] = r.new_value;
        o.status = STATUS_UPDATED;
      end else if (used_count < TABLE_ENTRIES) begin
        idx = used_count;
        name_low_tbl[idx] = lo;
        name_high_tbl[idx] = hi;
        name_len_tbl[idx] = keep[7:0];
        value_tbl[idx] = r.new_value;
        used_count++;
        o.status = STATUS_INSERTED;
      end else begin
        o.status = STATUS_FULL;
      end
    end
    if (!hit && o.status != STATUS_INSERTED) idx = 0;
    o.entry_index = idx[5:0];
    o.entries_used = used_count[6:0];
    return o;
  endfunction

  function automatic req_t random_request(input int n);
    req_t r;
    int pick;
    int active;
    int slot;
    int len;
    logic [119:0] key;
    key = 120'({$urandom, $urandom, $urandom, $urandom});
    pick = $urandom_range(99);
    if (pick < 80) begin
      // The set of names in use grows slowly, so the table fills over the run.
      active = (4 + n / 20 < POOL_NAMES) ? 4 + n / 20 : POOL_NAMES;
      slot = $urandom_range(active - 1);
      len = pool_len[slot];
      for (int b = 0; b < MAX_CHARS; b++) if (b < len) key[8*b +: 8] = pool_chars[slot][8*b +: 8];
    end else if (pick < 95) begin
      len = $urandom_range(MAX_CHARS);
    end else if (pick < 98) begin
      len = $urandom_range(255, MAX_CHARS + 1);
    end else begin
      len = $urandom_range(2);
      for (int b = 0; b < 2; b++) if (b < len) key[8*b +: 8] = $urandom_range(1) ? 8'hFF : 8'h00;
    end
    r.opcode = ($urandom_range(99) < 35) ? OP_SET : OP_LOOKUP;
    r.key_chars_low = key[63:0];
    r.key_chars_high = key[119:64];
    r.key_length = len[7:0];
    case ($urandom_range(19))
      0: r.new_value = 32'sh7FFF_FFFF;
      1: r.new_value = 32'sh8000_0000;
      2: r.new_value = 32'sd0;
      3: r.new_value = -32'sd1;
      default: r.new_value = $urandom;
    endcase
    return r;
  endfunction

  task automatic add_row(input logic op, input logic [63:0] lo, input logic [55:0] hi,
                         input logic [7:0] len, input logic signed [31:0] val,
                         input logic typed, input logic signed [31:0] rv, input logic hit,
                         input logic [1:0] st, input logic [5:0] ix, input logic [6:0] used);
    row_t row;
    row.req = '{opcode: op, key_chars_low: lo, key_chars_high: hi, key_length: len,
                new_value: val};
    row.typed = typed;
    row.want = '{read_value: rv, found: hit, status: st, entry_index: ix, entries_used: used};
    directed_rows.push_back(row);
  endtask

  task automatic send_request(input req_t r, input int gap, input logic typed,
                              input rsp_t typed_rsp);
    rsp_t predicted;
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd <= r;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (cmd_stall !== 1'b0);
    predicted = store_access(r);
    expected_results.push_back(typed ? typed_rsp : predicted);
  endtask

  task automatic check_result(input rsp_t got);
    rsp_t want;
    if (expected_results.size() == 0) begin
      $error("result with no request outstanding: read_value %0d", got.read_value);
      failures++;
      return;
    end
    want = expected_results.pop_front();
    if (got.read_value !== want.read_value) begin
      $error("read_value: expected %0d, got %0d", want.read_value, got.read_value);
      failures++;
    end
    if (got.found !== want.found) begin
      $error("found: expected %0d, got %0d", want.found, got.found);
      failures++;
    end
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      failures++;
    end
    if (got.entry_index !== want.entry_index) begin
      $error("entry_index: expected %0d, got %0d", want.entry_index, got.entry_index);
      failures++;
    end
    if (got.entries_used !== want.entries_used) begin
      $error("entries_used: expected %0d, got %0d", want.entries_used, got.entries_used);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    if ((cmd_valid && !cmd_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_named_variable_store NOT OK");
      $finish;
    end
  end

  initial begin : result_side
    int hold;
    int taken;
    taken = 0;
    while (rst) @(posedge clk);
    forever begin
      hold = ((taken / 130) % 3 == 2) ? 0 : $urandom_range(12);
      // One long hold-off lets the block back up into its request side.
      if (taken == PRESSURE_AT) hold = PRESSURE_HOLD;
      if (hold > 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      result_stall <= 1'b0;
      do @(posedge clk); while (result_valid !== 1'b1);
      check_result(result);
      taken++;
    end
  end

  initial begin : request_side
    int gap;
    for (int i = 0; i < POOL_NAMES; i++) begin
      pool_len[i] = $urandom_range(MAX_CHARS);
      pool_chars[i] = 120'({$urandom, $urandom, $urandom, $urandom});
    end

    // Empty table, then the empty name, one-character names with stray bytes past the
    // length, full-length and over-long names, names made of zero bytes, word boundary.
    add_row(OP_LOOKUP, 64'h0, 56'h0, 8'd0, 32'sd5,
            1'b1, 32'sd0, 1'b0, STATUS_LOOKUP, 6'd0, 7'd0);
    add_row(OP_LOOKUP, 64'h61, 56'h0, 8'd1, 32'sd0,
            1'b1, 32'sd0, 1'b0, STATUS_LOOKUP, 6'd0, 7'd0);
    add_row(OP_SET, '1, '1, 8'd0, 32'sh7FFF_FFFF,
            1'b1, 32'sh7FFF_FFFF, 1'b0, STATUS_INSERTED, 6'd0, 7'd1);
    add_row(OP_LOOKUP, 64'h0, 56'h0, 8'd0, -32'sd1,
            1'b1, 32'sh7FFF_FFFF, 1'b1, STATUS_LOOKUP, 6'd0, 7'd1);
    add_row(OP_SET, 64'hFFFF_FFFF_FFFF_FF78, 56'h0, 8'd1, 32'sh8000_0000,
            1'b1, 32'sh8000_0000, 1'b0, STATUS_INSERTED, 6'd1, 7'd2);
    add_row(OP_LOOKUP, 64'h0000_0000_0000_1278, 56'h0, 8'd1, 32'sd0,
            1'b1, 32'sh8000_0000, 1'b1, STATUS_LOOKUP, 6'd1, 7'd2);
    add_row(OP_SET, 64'h78, 56'h0, 8'd1, -32'sd1,
            1'b1, -32'sd1, 1'b1, STATUS_UPDATED, 6'd1, 7'd2);
    add_row(OP_SET, '1, '1, 8'd15, 32'sd0,
            1'b1, 32'sd0, 1'b0, STATUS_INSERTED, 6'd2, 7'd3);
    add_row(OP_LOOKUP, '1, '1, 8'd15, 32'sd0,
            1'b1, 32'sd0, 1'b1, STATUS_LOOKUP, 6'd2, 7'd3);
    add_row(OP_LOOKUP, '1, '1, 8'd14, 32'sd0,
            1'b1, 32'sd0, 1'b0, STATUS_LOOKUP, 6'd0, 7'd3);
    add_row(OP_SET, '1, '1, 8'd16, 32'sd1,
            1'b1, 32'sd1, 1'b0, STATUS_INSERTED, 6'd3, 7'd4);
    add_row(OP_LOOKUP, '1, '1, 8'd16, 32'sd0,
            1'b1, 32'sd0, 1'b0, STATUS_LOOKUP, 6'd0, 7'd4);
    add_row(OP_SET, '1, '1, 8'd255, 32'sd2,
            1'b1, 32'sd2, 1'b0, STATUS_INSERTED, 6'd4, 7'd5);
    add_row(OP_LOOKUP, '1, '1, 8'd15, 32'sd0,
            1'b1, 32'sd0, 1'b1, STATUS_LOOKUP, 6'd2, 7'd5);
    add_row(OP_SET, 64'h0, 56'h0, 8'd3, 32'sh1234_5678,
            1'b1, 32'sh1234_5678, 1'b0, STATUS_INSERTED, 6'd5, 7'd6);
    add_row(OP_LOOKUP, 64'h0, 56'h0, 8'd3, 32'sd0,
            1'b1, 32'sh1234_5678, 1'b1, STATUS_LOOKUP, 6'd5, 7'd6);
    add_row(OP_LOOKUP, 64'h0, 56'h0, 8'd2, 32'sd0,
            1'b1, 32'sd0, 1'b0, STATUS_LOOKUP, 6'd0, 7'd6);
    add_row(OP_SET, 64'h0123_4567_89AB_CDEF, 56'hAA_AAAA_AAAA_AAAA, 8'd8, 32'sd12345,
            1'b0, 32'sd0, 1'b0, STATUS_LOOKUP, 6'd0, 7'd0);
    add_row(OP_LOOKUP, 64'h0123_4567_89AB_CDEF, 56'h0, 8'd9, 32'sd0,
            1'b0, 32'sd0, 1'b0, STATUS_LOOKUP, 6'd0, 7'd0);
    add_row(OP_LOOKUP, 64'h0123_4567_89AB_CDEF, 56'h55_5555_5555_5555, 8'd8, 32'sd0,
            1'b0, 32'sd0, 1'b0, STATUS_LOOKUP, 6'd0, 7'd0);
    add_row(OP_SET, 64'h0123_4567_89AB_CDEF, 56'hFF_FFFF_FFFF_FF5A, 8'd9, -32'sd7,
            1'b0, 32'sd0, 1'b0, STATUS_LOOKUP, 6'd0, 7'd0);
    add_row(OP_SET, 64'h0, 56'h0, 8'd0, 32'sd0,
            1'b0, 32'sd0, 1'b0, STATUS_LOOKUP, 6'd0, 7'd0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].req, $urandom_range(12), directed_rows[i].typed,
                   directed_rows[i].want);
    end
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      gap = ((n / 150) % 3 == 1) ? 0 : $urandom_range(12);
      send_request(random_request(n), gap, 1'b0, '0);
    end
    cmd_valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("tb_named_variable_store OK");
    end else begin
      $display("tb_named_variable_store NOT OK");
    end
    $finish;
  end

endmodule
